@@ rtl/bpas_pkg.sv @@
// bpas_pkg: widths shared by the bresenham point-at-step unit
// no dependencies

package bpas_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int STEP_WIDTH  = 16;

    // move counter covers both the step count and the largest dx
    localparam int MOVE_WIDTH  = (COORD_WIDTH > STEP_WIDTH) ? COORD_WIDTH : STEP_WIDTH;

    // error increments: 2*dy fits in COORD_WIDTH+2, 2*dy - 2*dx in COORD_WIDTH+3
    localparam int INC_WIDTH   = COORD_WIDTH + 3;

    // error term after up to dx moves stays below 2^(2*COORD_WIDTH+3) in magnitude
    localparam int ERR_WIDTH   = 2 * COORD_WIDTH + 4;

endpackage

@@ rtl/bresenham_point_at_step_unit.sv @@
// bresenham_point_at_step_unit: point reached on a line after a number of moves
// depends on bpas_pkg

// One request carries a start point, an end point and a step count; the
// unit returns the point reached after min(step_count, dx) Bresenham moves,
// where the endpoints are swapped first if the start lies right of the end.
// From acceptance until its result is presented, a request passes through
// ST_DIFF, which forms dx and dy, ST_INIT, which sets up the error term and
// the move count, and ST_RUN, which makes the moves one at a time on the
// single shared error adder, then writes the output register. s_ready is
// high only while the sequencer is idle. The result sits in an output
// register, so a new request is taken while the previous result still waits
// for m_ready; the sequencer stalls only if a second result is finished
// before the first has been taken.

module bresenham_point_at_step_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [bpas_pkg::COORD_WIDTH-1:0] s_start_x,
    input  logic signed [bpas_pkg::COORD_WIDTH-1:0] s_start_y,
    input  logic signed [bpas_pkg::COORD_WIDTH-1:0] s_end_x,
    input  logic signed [bpas_pkg::COORD_WIDTH-1:0] s_end_y,
    input  logic        [bpas_pkg::STEP_WIDTH-1:0]  s_step_count,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [bpas_pkg::COORD_WIDTH-1:0] m_point_x,
    output logic signed [bpas_pkg::COORD_WIDTH-1:0] m_point_y
);

    import bpas_pkg::*;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIFF,
        ST_INIT,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;

    // working point (start after swap) and end point
    logic signed [COORD_WIDTH-1:0] x_reg, x_next;
    logic signed [COORD_WIDTH-1:0] y_reg, y_next;
    logic signed [COORD_WIDTH-1:0] ex_reg, ex_next;
    logic signed [COORD_WIDTH-1:0] ey_reg, ey_next;
    logic        [STEP_WIDTH-1:0]  steps_reg, steps_next;

    // line deltas; dx is never negative after the swap
    logic        [COORD_WIDTH-1:0] dx_reg, dx_next;
    logic signed [COORD_WIDTH:0]   dy_reg, dy_next;

    // error term and its two increments
    logic signed [ERR_WIDTH-1:0]   err_reg, err_next;
    logic signed [INC_WIDTH-1:0]   inc_up_reg, inc_up_next;
    logic signed [INC_WIDTH-1:0]   inc_flat_reg, inc_flat_next;

    // moves still to make
    logic        [MOVE_WIDTH-1:0]  remain_reg, remain_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic signed [COORD_WIDTH-1:0] point_x_reg, point_x_next;
    logic signed [COORD_WIDTH-1:0] point_y_reg, point_y_next;

    logic                          out_free;
    logic                          swap;
    logic signed [COORD_WIDTH:0]   dx_wide;
    logic signed [INC_WIDTH-1:0]   dy2;
    logic signed [INC_WIDTH-1:0]   dx2;
    logic        [MOVE_WIDTH-1:0]  dx_moves;
    logic        [MOVE_WIDTH-1:0]  steps_moves;
    logic                          err_pos;

    assign out_free    = !m_valid_reg || m_ready;
    assign swap        = s_start_x > s_end_x;

    assign dx_wide     = (COORD_WIDTH+1)'(ex_reg) - (COORD_WIDTH+1)'(x_reg);
    assign dy2         = INC_WIDTH'(dy_reg) <<< 1;
    assign dx2         = $signed({2'b00, dx_reg, 1'b0});
    assign dx_moves    = MOVE_WIDTH'(dx_reg);
    assign steps_moves = MOVE_WIDTH'(steps_reg);
    assign err_pos     = !err_reg[ERR_WIDTH-1] && (err_reg != '0);

    always_comb begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        ex_next       = ex_reg;
        ey_next       = ey_reg;
        steps_next    = steps_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        err_next      = err_reg;
        inc_up_next   = inc_up_reg;
        inc_flat_next = inc_flat_reg;
        remain_next   = remain_reg;
        m_valid_next  = m_valid_reg;
        point_x_next  = point_x_reg;
        point_y_next  = point_y_reg;

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // leftmost point becomes the start
                    x_next     = swap ? s_end_x   : s_start_x;
                    y_next     = swap ? s_end_y   : s_start_y;
                    ex_next    = swap ? s_start_x : s_end_x;
                    ey_next    = swap ? s_start_y : s_end_y;
                    steps_next = s_step_count;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                dx_next    = dx_wide[COORD_WIDTH-1:0];
                dy_next    = (COORD_WIDTH+1)'(ey_reg) - (COORD_WIDTH+1)'(y_reg);
                state_next = ST_INIT;
            end
            ST_INIT: begin
                err_next      = ERR_WIDTH'(dy2) - ERR_WIDTH'(dx_reg);
                inc_flat_next = dy2;
                inc_up_next   = dy2 - dx2;
                // move count saturates at dx
                remain_next   = (dx_moves < steps_moves) ? dx_moves : steps_moves;
                state_next    = ST_RUN;
            end
            ST_RUN: begin
                if (remain_reg != '0) begin
                    // one bresenham move
                    x_next      = x_reg + COORD_WIDTH'(1);
                    remain_next = remain_reg - MOVE_WIDTH'(1);
                    if (err_pos) begin
                        y_next   = y_reg + COORD_WIDTH'(1);
                        err_next = err_reg + ERR_WIDTH'(inc_up_reg);
                    end else begin
                        err_next = err_reg + ERR_WIDTH'(inc_flat_reg);
                    end
                end else if (out_free) begin
                    // hand the point to the output register
                    point_x_next = x_reg;
                    point_y_next = y_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            ex_reg       <= ex_next;
            ey_reg       <= ey_next;
            steps_reg    <= steps_next;
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            err_reg      <= err_next;
            inc_up_reg   <= inc_up_next;
            inc_flat_reg <= inc_flat_next;
            remain_reg   <= remain_next;
            point_x_reg  <= point_x_next;
            point_y_reg  <= point_y_next;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_point_x = point_x_reg;
    assign m_point_y = point_y_reg;

    // distance left to the end point, for the overrun check
    logic [COORD_WIDTH:0] to_end;
    assign to_end = (COORD_WIDTH+1)'(ex_reg) - (COORD_WIDTH+1)'(x_reg);

    // remaining moves never carry x past the end point
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |->
            (!to_end[COORD_WIDTH] && (MOVE_WIDTH'(to_end[COORD_WIDTH-1:0]) >= remain_reg)))
        else $error("move count would pass the end point");

    // finished point with a free output slot shows up as a result next cycle
    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && remain_reg == '0 && out_free) |=>
            (m_valid_reg && state_reg == ST_IDLE && m_point_x == $past(x_reg)))
        else $error("finished point not presented");

endmodule

@@ tb/sv/tb.sv @@
// tb: self-checking testbench for bresenham_point_at_step_unit
// predicts the point reached on each line in place and checks every result in order
// depends on bpas_pkg and the rtl of the unit
`timescale 1ns / 1ps

module tb;
    import bpas_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [STEP_WIDTH-1:0]  count_t;
    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    localparam longint COORD_MAX        = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN        = -COORD_MAX - 1;
    localparam int     LONG_HOLD_CYCLES = 80;   // long receiver hold-off, fills the unit
    localparam int     TAIL_CYCLES      = 16;   // quiet cycles after the last result
    localparam int     MAX_PRINTED      = 40;   // keep the log short on a bad rtl

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    coord_t s_start_x;
    coord_t s_start_y;
    coord_t s_end_x;
    coord_t s_end_y;
    count_t s_step_count;
    logic   m_valid;
    logic   m_ready;
    coord_t m_point_x;
    coord_t m_point_y;

    // expected points, oldest first
    point_t expected_points[$];
    point_t want;

    int mismatch_count  = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int swapped_lines   = 0;
    int long_holds      = 0;

    // knobs shared between the stimulus and the result sink
    bit sender_idle_on   = 1'b1;
    bit receiver_idle_on = 1'b1;
    bit hold_req         = 1'b0;

    bresenham_point_at_step_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_step_count (s_step_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_point_x    (m_point_x),
        .m_point_y    (m_point_y)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #40ms;
        $display("tb: errors");
        $finish;
    end

    // point reached after min(steps, dx) moves, ends swapped if the start lies right
    // of the end; error term is kept in 64 bits so it can never overflow
    function automatic point_t point_after_moves(coord_t sx, coord_t sy, coord_t ex,
                                                 coord_t ey, count_t steps);
        longint x0, y0, x1, y1, t, dx, dy, err, moves, k;
        point_t p;
        x0 = longint'(sx);
        y0 = longint'(sy);
        x1 = longint'(ex);
        y1 = longint'(ey);
        if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
        end
        dx    = x1 - x0;
        dy    = y1 - y0;
        moves = longint'(steps);
        if (dx < moves) moves = dx;
        err = 2 * dy - dx;
        for (k = 0; k < moves; k++) begin
            x0++;
            if (err > 0) begin
                y0++;
                err += 2 * dy - 2 * dx;
            end else begin
                err += 2 * dy;
            end
        end
        p.x = x0[COORD_WIDTH-1:0];
        p.y = y0[COORD_WIDTH-1:0];
        return p;
    endfunction

    function automatic coord_t clamp_coord(longint v);
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return v[COORD_WIDTH-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) $display("tb: mismatch: %s", msg);
    endtask

    // offer one request, with an occasional gap in front; valid stays high
    // afterwards so back-to-back requests follow without a gap
    task automatic send_request(input coord_t sx, sy, ex, ey, input count_t steps);
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_start_x    <= sx;
        s_start_y    <= sy;
        s_end_x      <= ex;
        s_end_y      <= ey;
        s_step_count <= steps;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_points.push_back(point_after_moves(sx, sy, ex, ey, steps));
        requests_sent++;
        if (sx > ex) swapped_lines++;
    endtask

    // sender stops offering until every outstanding result has been taken
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_points.size() != 0);
    endtask

    // random line shapes; moves stay short (300 at most) so the run
    // stays fast, while every coordinate and step bit still toggles
    task automatic random_line(output coord_t sx, sy, ex, ey, output count_t steps);
        int kind;
        int off_x;
        int off_y;
        kind  = $urandom_range(0, 9);
        off_x = $urandom_range(0, 600);
        off_y = $urandom_range(0, 4000);
        sx    = coord_t'($urandom);
        sy    = coord_t'($urandom);
        ex    = coord_t'($urandom);
        ey    = coord_t'($urandom);
        steps = count_t'($urandom_range(0, 300));
        case (kind)
            4, 5, 6, 7: begin
                // short line, any slope; full-range step count saturates at dx
                ex    = clamp_coord(longint'(sx) + off_x - 300);
                ey    = clamp_coord(longint'(sy) + off_y - 2000);
                steps = count_t'($urandom);
            end
            8: begin
                // vertical line, nothing moves
                ex    = sx;
                steps = count_t'($urandom);
            end
            9: begin
                steps = count_t'($urandom_range(0, 3));
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-picked lines: zero step, capping at the line end, swapped ends,
    // vertical, falling and steep slopes, and the coordinate extremes
    task automatic test_directed_lines();
        send_request(0, 0, 0, 0, 0);
        send_request(-100, 40, 300, 90, 0);             // step zero returns start
        send_request(0, 0, 10, 0, 3);                   // horizontal
        send_request(0, 0, 10, 0, 10);                  // lands exactly on the end
        send_request(0, 0, 10, 0, 20);                  // step beyond end is capped
        send_request(-7, -7, 13, 13, 9);                // 45 degrees
        send_request(10, 5, 0, 0, 4);                   // swapped ends
        send_request(5, -7, 5, 100, 9);                 // vertical, no move
        send_request(0, 0, 20, -15, 20);                // falling line, y stays put
        send_request(0, 0, 5, 50, 5);                   // steep, y rises every move
        send_request(3, 1, 17, 6, 11);                  // shallow first octant
        send_request(16'h7fff, -32768, 16'h7fff, 32767, 16'hffff);  // vertical extreme
        send_request(-32768, 5, -32767, 9, 16'hffff);   // unit dx, full step count
        send_request(32767, 32767, -32768, -32768, 1000);           // swapped, long
        send_request(-32768, -32768, 32767, 32767, 16'hffff);       // full diagonal
        send_request(-32768, 32767, 32767, -32768, 16'hffff);       // full falling
        send_request(-32768, 0, 32767, 1, 16'hffff);    // longest shallow line
        send_request(-20000, 100, 0, 7000, 12345);      // deep into a long line
        wait_drained();
    endtask

    // bulk random lines; idling on both sides comes and goes in stretches,
    // with one full drain half way through
    task automatic test_random_lines(input int n);
        coord_t sx, sy, ex, ey;
        count_t steps;
        for (int i = 0; i < n; i++) begin
            sender_idle_on   = ((i / 60) % 4) != 3;
            receiver_idle_on = ((i / 45) % 4) != 2;
            if (i == n / 2) wait_drained();
            random_line(sx, sy, ex, ey, steps);
            send_request(sx, sy, ex, ey, steps);
        end
        wait_drained();
    endtask

    // receiver holds off for a long stretch while short requests keep coming,
    // so the output register and the sequencer both fill and s_ready drops
    task automatic test_output_backpressure();
        coord_t sx, sy, ex, ey;
        count_t steps;
        int     off;
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        for (int r = 0; r < 4; r++) begin
            hold_req = 1'b1;
            for (int j = 0; j < 6; j++) begin
                off   = $urandom_range(0, 20);
                sx    = coord_t'($urandom);
                sy    = coord_t'($urandom);
                ex    = clamp_coord(longint'(sx) + off - 10);
                ey    = clamp_coord(longint'(sy) + off - 10);
                steps = count_t'($urandom_range(0, 8));
                send_request(sx, sy, ex, ey, steps);
            end
        end
        wait_drained();
    endtask

    // closing stretch at full rate, no idling anywhere
    task automatic test_streaming_no_idle(input int n);
        coord_t sx, sy, ex, ey;
        count_t steps;
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        for (int i = 0; i < n; i++) begin
            random_line(sx, sy, ex, ey, steps);
            send_request(sx, sy, ex, ey, steps);
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // result sink: random stall bursts, plus the long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_holds++;
            end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // result checker: every accepted point against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                report_mismatch($sformatf("unexpected point (%0d, %0d)",
                                          m_point_x, m_point_y));
            end else begin
                want = expected_points.pop_front();
                if (m_point_x !== want.x)
                    report_mismatch($sformatf("point_x %0d, expected %0d (result %0d)",
                                              m_point_x, want.x, results_checked));
                if (m_point_y !== want.y)
                    report_mismatch($sformatf("point_y %0d, expected %0d (result %0d)",
                                              m_point_y, want.y, results_checked));
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        // every input known from time zero
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_start_x    <= '0;
        s_start_y    <= '0;
        s_end_x      <= '0;
        s_end_y      <= '0;
        s_step_count <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_lines();
        test_random_lines(650);
        test_output_backpressure();
        test_streaming_no_idle(200);

        // let any stray late result show up before judging
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("tb: %0d line requests (%0d with swapped ends), %0d points checked",
                 requests_sent, swapped_lines, results_checked);
        $display("tb: %0d long output hold-offs, idle bursts on both sides", long_holds);
        if (mismatch_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bpas_pkg.sv
rtl/bresenham_point_at_step_unit.sv
tb/sv/tb.sv
